// File: rtl/assert_macros.svh
// Assertion macros used by the checker file tcq_checker.sv.
// Depends on nothing; expects i_clk and i_rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is low.
`define TCQ_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
// Next-cycle implication, disabled while reset is low.
`define TCQ_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");
`endif

// File: rtl/tcq_pkg.sv
// Shared types, codes and defaults for the two-class rate-limited queue.
// Depends on nothing; used by every module of the block but tcq_queue.
package tcq_pkg;

    localparam int TCQ_QUEUE_DEPTH = 16;
    localparam int TCQ_MAX_LIMIT   = 64;
    localparam int TCQ_TIME_WIDTH  = 32;

    localparam logic [1:0] OP_ENQ      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;

    localparam logic [2:0] ST_QUEUED    = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_TICKED    = 3'd2;
    localparam logic [2:0] ST_SENT      = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;
    localparam logic [2:0] ST_THROTTLED = 3'd5;

    localparam logic [1:0] CFG_SEND_LIMIT = 2'd0;
    localparam logic [1:0] CFG_WINDOW     = 2'd1;

    localparam logic [6:0]  SEND_LIMIT_RESET = 7'd0;
    localparam logic [31:0] WINDOW_RESET     = 32'd1000000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] message_handle;
        logic        low_priority;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sent_handle;
        logic        sent_low_priority;
        logic [31:0] latency_ticks;
        logic [5:0]  queued_total;
        logic [6:0]  window_count;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_ENQ,
        CMD_TICK,
        CMD_DISPATCH,
        CMD_NOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] handle;
        logic        low_priority;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_PRUNE_RD,
        BS_PRUNE_CHK,
        BS_DECIDE
    } t_bstate;

endpackage

// File: rtl/tcq_queue.sv
// Two-entry register queue used between the front and back and on the result side.
// Depends on nothing.
module tcq_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr, n_wr;
    logic             r_rd, n_rd;
    logic [1:0]       r_cnt, n_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_comb begin
        n_wr  = push_ok ? ~r_wr : r_wr;
        n_rd  = pop_ok ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(push_ok) - 2'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: rtl/tcq_front.sv
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on tcq_pkg and tcq_queue.
module tcq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  tcq_pkg::t_in_item i_in,
    output tcq_pkg::t_cmd_q   o_cmd,
    input  logic              i_cmd_pop
);

    tcq_pkg::t_cmd           cmd;
    logic [$bits(cmd)-1:0]   cq_data;
    logic                    cq_empty;

    always_comb begin
        cmd.handle       = i_in.message_handle;
        cmd.low_priority = i_in.low_priority;
        unique case (i_in.op)
            tcq_pkg::OP_ENQ:      cmd.kind = tcq_pkg::CMD_ENQ;
            tcq_pkg::OP_TICK:     cmd.kind = tcq_pkg::CMD_TICK;
            tcq_pkg::OP_DISPATCH: cmd.kind = tcq_pkg::CMD_DISPATCH;
            default:              cmd.kind = tcq_pkg::CMD_NOP;
        endcase
    end

    tcq_queue #(
        .WIDTH($bits(cmd))
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd),
        .o_full  (o_full),
        .o_empty (cq_empty),
        .i_pop   (i_cmd_pop),
        .o_data  (cq_data)
    );

    assign o_cmd.valid = !cq_empty;
    assign o_cmd.cmd   = cq_data;

endmodule

// File: rtl/tcq_back.sv
// Back end: class FIFOs, send-time ring, tick counter, config registers and result queue.
// Depends on tcq_pkg and tcq_queue.
module tcq_back #(
    parameter int QUEUE_DEPTH = tcq_pkg::TCQ_QUEUE_DEPTH,
    parameter int MAX_LIMIT   = tcq_pkg::TCQ_MAX_LIMIT,
    parameter int TIME_WIDTH  = tcq_pkg::TCQ_TIME_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tcq_pkg::t_cmd_q    i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_empty,
    input  logic               i_pop,
    output tcq_pkg::t_out_item o_out
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int RAW = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
    localparam int RCW = $clog2(MAX_LIMIT + 1);
    localparam int TW  = TIME_WIDTH;
    localparam int EW  = TIME_WIDTH + 32;
    localparam int LW  = RCW + 7;
    localparam int SW  = QCW + 7;
    localparam int DW  = TIME_WIDTH + 16;

    localparam logic [QCW:0]   QD_X   = (QCW + 1)'(QUEUE_DEPTH);
    localparam logic [QCW-1:0] QD_C   = QCW'(QUEUE_DEPTH);
    localparam logic [QAW-1:0] Q_LAST = QAW'(QUEUE_DEPTH - 1);
    localparam logic [RCW:0]   ML_X   = (RCW + 1)'(MAX_LIMIT);
    localparam logic [RCW-1:0] ML_C   = RCW'(MAX_LIMIT);
    localparam logic [RAW-1:0] R_LAST = RAW'(MAX_LIMIT - 1);
    localparam logic [LW-1:0]  ML_L   = LW'(MAX_LIMIT);

    tcq_pkg::t_bstate r_state, n_state;
    logic [QAW-1:0]   r_u_rd, n_u_rd, r_n_rd, n_n_rd;
    logic [QCW-1:0]   r_u_cnt, n_u_cnt, r_n_cnt, n_n_cnt;
    logic [RAW-1:0]   r_ring_head, n_ring_head;
    logic [RCW-1:0]   r_ring_cnt, n_ring_cnt;
    logic [TW-1:0]    r_time, n_time;
    logic [6:0]       r_send_limit;
    logic [31:0]      r_window;

    logic [DW-1:0]    r_u_mem [QUEUE_DEPTH];
    logic [DW-1:0]    r_n_mem [QUEUE_DEPTH];
    logic [TW-1:0]    r_ring_mem [MAX_LIMIT];
    logic [DW-1:0]    r_u_q, r_n_q;
    logic [TW-1:0]    r_ring_q;

    logic             q_we_u, q_we_n;
    logic [QAW-1:0]   q_waddr;
    logic [QAW-1:0]   sel_rd;
    logic [QCW-1:0]   sel_cnt;
    logic [QCW:0]     q_wsum;
    logic             ring_we;
    logic [RAW-1:0]   ring_waddr;
    logic [RCW:0]     r_wsum;
    logic [TW-1:0]    prune_age;
    logic [LW-1:0]    lim;
    logic             throttle;
    logic             record;
    logic [DW-1:0]    entry;
    logic [TW-1:0]    lat_age;
    logic [EW-1:0]    lat_ext;
    logic [SW-1:0]    tot;
    logic [LW-1:0]    wc_ext;
    logic             rq_push;
    logic             rq_full;
    tcq_pkg::t_out_item res;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        sel_rd  = i_cmd.cmd.low_priority ? r_n_rd : r_u_rd;
        sel_cnt = i_cmd.cmd.low_priority ? r_n_cnt : r_u_cnt;
        q_wsum  = (QCW + 1)'(sel_rd) + (QCW + 1)'(sel_cnt);
        if (q_wsum >= QD_X) begin
            q_wsum = q_wsum - QD_X;
        end
        q_waddr = q_wsum[QAW-1:0];
        r_wsum  = (RCW + 1)'(r_ring_head) + (RCW + 1)'(r_ring_cnt);
        if (r_wsum >= ML_X) begin
            r_wsum = r_wsum - ML_X;
        end
        ring_waddr = r_wsum[RAW-1:0];
        prune_age  = r_time - r_ring_q;
        lim        = (LW'(r_send_limit) > ML_L) ? ML_L : LW'(r_send_limit);
        throttle   = (lim != '0) && (LW'(r_ring_cnt) >= lim);
        record     = (lim != '0) && (r_ring_cnt < ML_C);
        entry      = (r_u_cnt == '0) ? r_n_q : r_u_q;
        lat_age    = r_time - entry[TW-1:0];
        lat_ext    = EW'(lat_age);
    end

    always_comb begin
        n_state     = r_state;
        n_u_rd      = r_u_rd;
        n_n_rd      = r_n_rd;
        n_u_cnt     = r_u_cnt;
        n_n_cnt     = r_n_cnt;
        n_ring_head = r_ring_head;
        n_ring_cnt  = r_ring_cnt;
        n_time      = r_time;
        o_cmd_pop   = 1'b0;
        q_we_u      = 1'b0;
        q_we_n      = 1'b0;
        ring_we     = 1'b0;
        rq_push     = 1'b0;
        res.status            = tcq_pkg::ST_NONE;
        res.sent_handle       = 16'd0;
        res.sent_low_priority = 1'b0;
        res.latency_ticks     = 32'd0;
        unique case (r_state)
            tcq_pkg::BS_IDLE: begin
                if (i_cmd.valid && !rq_full) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.cmd.kind)
                        tcq_pkg::CMD_ENQ: begin
                            rq_push = 1'b1;
                            if (sel_cnt >= QD_C) begin
                                res.status = tcq_pkg::ST_FULL;
                            end else begin
                                res.status = tcq_pkg::ST_QUEUED;
                                if (i_cmd.cmd.low_priority) begin
                                    q_we_n  = 1'b1;
                                    n_n_cnt = r_n_cnt + 1'b1;
                                end else begin
                                    q_we_u  = 1'b1;
                                    n_u_cnt = r_u_cnt + 1'b1;
                                end
                            end
                        end
                        tcq_pkg::CMD_TICK: begin
                            rq_push    = 1'b1;
                            n_time     = r_time + 1'b1;
                            res.status = tcq_pkg::ST_TICKED;
                        end
                        tcq_pkg::CMD_DISPATCH: begin
                            n_state = tcq_pkg::BS_PRUNE_RD;
                        end
                        default: begin
                            rq_push    = 1'b1;
                            res.status = tcq_pkg::ST_NONE;
                        end
                    endcase
                end
            end
            tcq_pkg::BS_PRUNE_RD: begin
                n_state = tcq_pkg::BS_PRUNE_CHK;
            end
            tcq_pkg::BS_PRUNE_CHK: begin
                if ((r_ring_cnt != '0) && (EW'(prune_age) >= EW'(r_window))) begin
                    n_ring_head = (r_ring_head == R_LAST) ? '0 : r_ring_head + 1'b1;
                    n_ring_cnt  = r_ring_cnt - 1'b1;
                    n_state     = tcq_pkg::BS_PRUNE_RD;
                end else begin
                    n_state = tcq_pkg::BS_DECIDE;
                end
            end
            tcq_pkg::BS_DECIDE: begin
                rq_push = 1'b1;
                n_state = tcq_pkg::BS_IDLE;
                if ((r_u_cnt == '0) && (r_n_cnt == '0)) begin
                    res.status = tcq_pkg::ST_NONE;
                end else if (throttle) begin
                    res.status = tcq_pkg::ST_THROTTLED;
                end else begin
                    res.status            = tcq_pkg::ST_SENT;
                    res.sent_handle       = entry[DW-1:TW];
                    res.sent_low_priority = (r_u_cnt == '0);
                    res.latency_ticks     = (lat_ext > EW'(32'hFFFF_FFFF)) ?
                                            32'hFFFF_FFFF : lat_ext[31:0];
                    if (r_u_cnt == '0) begin
                        n_n_rd  = (r_n_rd == Q_LAST) ? '0 : r_n_rd + 1'b1;
                        n_n_cnt = r_n_cnt - 1'b1;
                    end else begin
                        n_u_rd  = (r_u_rd == Q_LAST) ? '0 : r_u_rd + 1'b1;
                        n_u_cnt = r_u_cnt - 1'b1;
                    end
                    if (record) begin
                        ring_we    = 1'b1;
                        n_ring_cnt = r_ring_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = tcq_pkg::BS_IDLE;
            end
        endcase
        tot    = SW'(n_u_cnt) + SW'(n_n_cnt);
        wc_ext = LW'(n_ring_cnt);
        res.queued_total = (tot > SW'(63)) ? 6'd63 : tot[5:0];
        res.window_count = (wc_ext > LW'(127)) ? 7'd127 : wc_ext[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcq_pkg::BS_IDLE;
            r_u_rd       <= '0;
            r_n_rd       <= '0;
            r_u_cnt      <= '0;
            r_n_cnt      <= '0;
            r_ring_head  <= '0;
            r_ring_cnt   <= '0;
            r_time       <= '0;
            r_send_limit <= tcq_pkg::SEND_LIMIT_RESET;
            r_window     <= tcq_pkg::WINDOW_RESET;
        end else begin
            r_state     <= n_state;
            r_u_rd      <= n_u_rd;
            r_n_rd      <= n_n_rd;
            r_u_cnt     <= n_u_cnt;
            r_n_cnt     <= n_n_cnt;
            r_ring_head <= n_ring_head;
            r_ring_cnt  <= n_ring_cnt;
            r_time      <= n_time;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tcq_pkg::CFG_SEND_LIMIT: r_send_limit <= i_cfg_data[6:0];
                    tcq_pkg::CFG_WINDOW:     r_window     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we_u) begin
            r_u_mem[q_waddr] <= {i_cmd.cmd.handle, r_time};
        end
        if (q_we_n) begin
            r_n_mem[q_waddr] <= {i_cmd.cmd.handle, r_time};
        end
        r_u_q <= r_u_mem[r_u_rd];
        r_n_q <= r_n_mem[r_n_rd];
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring_mem[ring_waddr] <= r_time;
        end
        r_ring_q <= r_ring_mem[r_ring_head];
    end

    tcq_queue #(
        .WIDTH($bits(tcq_pkg::t_out_item))
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (res),
        .o_full  (rq_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_out)
    );

endmodule

// File: rtl/two_class_queue_sliding_rate_limit.sv
// Flow: enqueue, tick and unused codes are handled in the idle state, which pushes their
// result; a dispatch repeats BS_PRUNE_RD and BS_PRUNE_CHK until the oldest send time is in
// the window, then BS_DECIDE pushes its result. Throughput: one enqueue or tick per cycle
// while the result queue has room; no new command is taken while a dispatch runs.
// Reset: synchronous, active low; clears pointers, counts and time, loads config defaults.
// Depends on tcq_pkg, tcq_front and tcq_back.
module two_class_queue_sliding_rate_limit #(
    parameter int QUEUE_DEPTH = tcq_pkg::TCQ_QUEUE_DEPTH,
    parameter int MAX_LIMIT   = tcq_pkg::TCQ_MAX_LIMIT,
    parameter int TIME_WIDTH  = tcq_pkg::TCQ_TIME_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tcq_pkg::t_in_item  i_in,
    output logic               empty,
    input  logic               pop,
    output tcq_pkg::t_out_item o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    tcq_pkg::t_cmd_q cmd_q;
    logic            cmd_pop;

    tcq_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_in      (i_in),
        .o_cmd     (cmd_q),
        .i_cmd_pop (cmd_pop)
    );

    tcq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_LIMIT   (MAX_LIMIT),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_q),
        .o_cmd_pop   (cmd_pop),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_out       (o_out)
    );

endmodule

// File: rtl/tcq_checker.sv
// Port-level checker for the two-class queue, bound to the top level below.
// Depends on tcq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcq_checker #(
    parameter int QUEUE_DEPTH = tcq_pkg::TCQ_QUEUE_DEPTH,
    parameter int MAX_LIMIT   = tcq_pkg::TCQ_MAX_LIMIT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input tcq_pkg::t_out_item o_out
);

    logic idle_zero;
    logic counts_ok;

    assign idle_zero = (o_out.sent_handle == 16'd0) && !o_out.sent_low_priority &&
                       (o_out.latency_ticks == 32'd0);
    assign counts_ok = (int'(o_out.queued_total) <= 2 * QUEUE_DEPTH) &&
                       (int'(o_out.window_count) <= MAX_LIMIT);

    `TCQ_ASSERT_IMP(a_status_range, !empty, o_out.status <= tcq_pkg::ST_THROTTLED)
    `TCQ_ASSERT_IMP(a_idle_fields_zero, !empty && (o_out.status != tcq_pkg::ST_SENT), idle_zero)
    `TCQ_ASSERT_IMP(a_count_bounds, !empty, counts_ok)
    `TCQ_ASSERT_NXT(a_stall_hold, !empty && !pop, !empty && $stable(o_out))

endmodule

bind two_class_queue_sliding_rate_limit tcq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_LIMIT   (MAX_LIMIT)
) u_tcq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);
